[src/asmp_pkg.sv]
// ----------------------------------------------------------------------------
// Archive symbol map parser package
// Shared status codes and the result word type for the symbol map parser.
// ----------------------------------------------------------------------------
package asmp_pkg;

  localparam int unsigned HDR_BYTES = 8;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_COUNT = 2'd1,
    ST_BAD_TABLE = 2'd2
  } status_t;

  typedef struct packed {
    logic        offset_valid;
    logic [63:0] offset_index;
    logic [63:0] member_offset;
    logic        done_res;
    status_t     status;
    logic [63:0] symbol_count;
  } result_t;

endpackage

[src/asmp_ifs.sv]
// ----------------------------------------------------------------------------
// Archive symbol map parser channels
// Valid/ready channels for the input bytes and for the result words.
// ----------------------------------------------------------------------------
interface asmp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       final_byte;

  modport source (output valid, output data_byte, output final_byte, input ready);
  modport sink (input valid, input data_byte, input final_byte, output ready);
endinterface

interface asmp_result_if;
  logic              valid;
  logic              ready;
  logic              offset_valid;
  logic [63:0]       offset_index;
  logic [63:0]       member_offset;
  logic              done_res;
  asmp_pkg::status_t status;
  logic [63:0]       symbol_count;

  modport source (output valid, output offset_valid, output offset_index,
                  output member_offset, output done_res, output status,
                  output symbol_count, input ready);
  modport sink (input valid, input offset_valid, input offset_index,
                input member_offset, input done_res, input status,
                input symbol_count, output ready);
endinterface

[src/asmp_step.sv]
// ----------------------------------------------------------------------------
// Archive symbol map parser step
// Holds the parse state and works out the result word for each byte.
// ----------------------------------------------------------------------------
module asmp_step (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [7:0]        data_byte,
  input  logic              final_byte,
  output logic              produced,
  output asmp_pkg::result_t result
);

  logic [63:0]       byte_position, byte_position_next;
  logic [63:0]       count_value, count_value_next;
  logic [63:0]       word_shift, word_shift_next;
  logic [63:0]       offsets_done, offsets_done_next;
  logic [63:0]       names_counted, names_counted_next;
  logic [7:0]        previous_byte, previous_byte_next;
  logic              string_bytes_seen, string_bytes_seen_next;
  asmp_pkg::status_t sticky_error, sticky_error_next;

  logic              in_header;
  logic              in_offsets;
  logic              got_offset;
  logic [63:0]       offsets_inc;
  logic              offsets_short;
  asmp_pkg::status_t status_value;

  always_comb begin
    in_header  = (byte_position[63:3] == 61'd0);
    in_offsets = !in_header && (offsets_done < count_value);
    got_offset = in_offsets && (byte_position[2:0] == 3'd7);
    offsets_inc = offsets_done + 64'd1;

    count_value_next  = in_header ? {count_value[55:0], data_byte} : count_value;
    offsets_done_next = got_offset ? offsets_inc : offsets_done;
    word_shift_next   = word_shift;
    if (in_offsets) begin
      word_shift_next = got_offset ? 64'd0 : {word_shift[55:0], data_byte};
    end

    names_counted_next     = names_counted;
    sticky_error_next      = sticky_error;
    previous_byte_next     = previous_byte;
    string_bytes_seen_next = string_bytes_seen;
    if (!in_header && !in_offsets) begin
      if (!string_bytes_seen) begin
        if (count_value != 64'd0 && data_byte == 8'd0 && sticky_error == asmp_pkg::ST_OK) begin
          sticky_error_next = asmp_pkg::ST_BAD_TABLE;
        end
      end else if (data_byte == 8'd0) begin
        if (previous_byte == 8'd0) begin
          if (names_counted < count_value && sticky_error == asmp_pkg::ST_OK) begin
            sticky_error_next = asmp_pkg::ST_BAD_TABLE;
          end
        end else if (!(&names_counted)) begin
          names_counted_next = names_counted + 64'd1;
        end
      end
      previous_byte_next     = data_byte;
      string_bytes_seen_next = 1'b1;
    end

    byte_position_next = (&byte_position) ? byte_position : byte_position + 64'd1;

    // Offsets stay zero throughout the header, so only the count decides there.
    if (in_header) begin
      offsets_short = (count_value_next != 64'd0);
    end else begin
      offsets_short = in_offsets && !(got_offset && offsets_inc == count_value);
    end

    status_value = asmp_pkg::ST_OK;
    if (final_byte) begin
      if (byte_position_next[63:3] == 61'd0 || offsets_short) begin
        status_value = asmp_pkg::ST_BAD_COUNT;
      end else if (sticky_error_next != asmp_pkg::ST_OK) begin
        status_value = sticky_error_next;
      end else if (count_value_next != 64'd0 && !string_bytes_seen_next) begin
        status_value = asmp_pkg::ST_BAD_TABLE;
      end else if (names_counted_next != count_value_next) begin
        status_value = asmp_pkg::ST_BAD_TABLE;
      end else if (data_byte != 8'd0) begin
        status_value = asmp_pkg::ST_BAD_TABLE;
      end
    end

    produced             = got_offset || final_byte;
    result.offset_valid  = got_offset;
    result.offset_index  = got_offset ? offsets_done : 64'd0;
    result.member_offset = got_offset ? {word_shift[55:0], data_byte} : 64'd0;
    result.done_res      = final_byte;
    result.status        = status_value;
    result.symbol_count  = (byte_position_next[63:3] == 61'd0) ? 64'd0 : count_value_next;
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && final_byte)) begin
      byte_position     <= 64'd0;
      count_value       <= 64'd0;
      word_shift        <= 64'd0;
      offsets_done      <= 64'd0;
      names_counted     <= 64'd0;
      previous_byte     <= 8'd0;
      string_bytes_seen <= 1'b0;
      sticky_error      <= asmp_pkg::ST_OK;
    end else if (accept) begin
      byte_position     <= byte_position_next;
      count_value       <= count_value_next;
      word_shift        <= word_shift_next;
      offsets_done      <= offsets_done_next;
      names_counted     <= names_counted_next;
      previous_byte     <= previous_byte_next;
      string_bytes_seen <= string_bytes_seen_next;
      sticky_error      <= sticky_error_next;
    end
  end

endmodule

[src/archive_symbol_map_parser_unit.sv]
// ----------------------------------------------------------------------------
// Archive symbol map parser
// Parses the 64-bit System V archive symbol map one byte per word.
// ----------------------------------------------------------------------------
//   channel      direction  words
//   byte_chan    in         one map byte, final_byte on the last one
//   result_chan  out        an offset, the end-of-map status, or both
//
// One byte is taken every cycle while byte_chan.ready is high; the result word of a
// byte that ends an offset or the map is registered. A skid register behind the
// result register holds one more result word while result_chan is stalled, so bytes
// keep moving until a second word waits; byte_chan.ready drops while the skid
// register is full. Reset is synchronous and clears all parse state.

module archive_symbol_map_parser_unit (
  input logic          clk,
  input logic          rst,
  asmp_byte_if.sink    byte_chan,
  asmp_result_if.source result_chan
);

  logic              accept;
  logic              produced;
  asmp_pkg::result_t step_result;

  logic              out_valid;
  asmp_pkg::result_t out_data;
  logic              skid_valid;
  asmp_pkg::result_t skid_data;
  logic              slot_free;

  assign byte_chan.ready = !skid_valid;
  assign accept          = byte_chan.valid && byte_chan.ready;
  assign slot_free       = !out_valid || result_chan.ready;

  asmp_step u_step (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .data_byte  (byte_chan.data_byte),
    .final_byte (byte_chan.final_byte),
    .produced   (produced),
    .result     (step_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (slot_free) begin
        if (skid_valid) begin
          out_valid  <= 1'b1;
          out_data   <= skid_data;
          skid_valid <= 1'b0;
        end else begin
          out_valid <= accept && produced;
          out_data  <= step_result;
        end
      end else if (accept && produced) begin
        skid_valid <= 1'b1;
        skid_data  <= step_result;
      end
    end
  end

  assign result_chan.valid         = out_valid;
  assign result_chan.offset_valid  = out_data.offset_valid;
  assign result_chan.offset_index  = out_data.offset_index;
  assign result_chan.member_offset = out_data.member_offset;
  assign result_chan.done_res      = out_data.done_res;
  assign result_chan.status        = out_data.status;
  assign result_chan.symbol_count  = out_data.symbol_count;

endmodule

[src/asmp_check.sv]
// ----------------------------------------------------------------------------
// Archive symbol map parser checks
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module asmp_check (
  input logic              clk,
  input logic              rst,
  input logic              out_valid,
  input logic              out_ready,
  input logic              offset_valid,
  input logic [63:0]       offset_index,
  input logic [63:0]       member_offset,
  input logic              done_res,
  input asmp_pkg::status_t status
);

  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(offset_index) &&
      $stable(member_offset) && $stable(status) && $stable(done_res))
    else $error("Stalled result word changed.");

  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> offset_valid || done_res)
    else $error("Result word carries neither an offset nor the end of the map.");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && !done_res |-> status == asmp_pkg::ST_OK)
    else $error("Error status before the end of the map.");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && !offset_valid |-> offset_index == 64'd0 && member_offset == 64'd0)
    else $error("Offset fields set without an offset.");

endmodule

bind archive_symbol_map_parser_unit asmp_check u_asmp_check (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (result_chan.valid),
  .out_ready     (result_chan.ready),
  .offset_valid  (result_chan.offset_valid),
  .offset_index  (result_chan.offset_index),
  .member_offset (result_chan.member_offset),
  .done_res      (result_chan.done_res),
  .status        (result_chan.status)
);

[bench/tb_archive_symbol_map_parser_unit.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Archive symbol map parser testbench
// Streams 64-bit symbol maps, well-formed ones and damaged ones, into the
// parser with random bursts and stalls. A directed table gives the result words of
// the first maps, a behavioral parser predicts those of the random maps, and the
// monitor compares each word field by field in order.

module tb_archive_symbol_map_parser_unit;

  localparam int RANDOM_BYTES = 750;
  localparam int CYCLE_LIMIT = 200000;

  typedef enum int {
    MAP_GOOD,
    MAP_CUT_HEADER,
    MAP_CUT_OFFSETS,
    MAP_NO_TABLE,
    MAP_LEAD_NUL,
    MAP_EXTRA_NUL,
    MAP_EXTRA_NAME,
    MAP_UNTERMINATED,
    MAP_PADDED,
    MAP_NOISE
  } map_kind_t;

  typedef struct packed {
    logic [7:0]        data;
    logic              last;
    logic              has_exp;
    asmp_pkg::result_t want;
  } table_row_t;

  localparam asmp_pkg::result_t NONE_RES = '0;
  localparam asmp_pkg::result_t CUT_HDR_RES =
    '{1'b0, 64'd0, 64'd0, 1'b1, asmp_pkg::ST_BAD_COUNT, 64'd0};
  localparam asmp_pkg::result_t FIRST_OFF_RES =
    '{1'b1, 64'd0, {64{1'b1}}, 1'b0, asmp_pkg::ST_OK, 64'd1};
  localparam asmp_pkg::result_t MAP_OK_RES =
    '{1'b0, 64'd0, 64'd0, 1'b1, asmp_pkg::ST_OK, 64'd1};

  localparam table_row_t DIRECTED [19] = '{
    '{8'hFF, 1'b1, 1'b1, CUT_HDR_RES},
    '{8'h00, 1'b0, 1'b0, NONE_RES},
    '{8'h00, 1'b0, 1'b0, NONE_RES},
    '{8'h00, 1'b0, 1'b0, NONE_RES},
    '{8'h00, 1'b0, 1'b0, NONE_RES},
    '{8'h00, 1'b0, 1'b0, NONE_RES},
    '{8'h00, 1'b0, 1'b0, NONE_RES},
    '{8'h00, 1'b0, 1'b0, NONE_RES},
    '{8'h01, 1'b0, 1'b0, NONE_RES},
    '{8'hFF, 1'b0, 1'b0, NONE_RES},
    '{8'hFF, 1'b0, 1'b0, NONE_RES},
    '{8'hFF, 1'b0, 1'b0, NONE_RES},
    '{8'hFF, 1'b0, 1'b0, NONE_RES},
    '{8'hFF, 1'b0, 1'b0, NONE_RES},
    '{8'hFF, 1'b0, 1'b0, NONE_RES},
    '{8'hFF, 1'b0, 1'b0, NONE_RES},
    '{8'hFF, 1'b0, 1'b1, FIRST_OFF_RES},
    '{8'h41, 1'b0, 1'b0, NONE_RES},
    '{8'h00, 1'b1, 1'b1, MAP_OK_RES}
  };

  logic clk;
  logic rst = 1'b1;

  asmp_byte_if byte_chan ();
  asmp_result_if result_chan ();

  archive_symbol_map_parser_unit dut (
    .clk         (clk),
    .rst         (rst),
    .byte_chan   (byte_chan),
    .result_chan (result_chan)
  );

  logic [63:0]       parse_pos;
  logic [63:0]       hdr_count;
  logic [63:0]       offset_acc;
  logic [63:0]       offsets_emitted;
  logic [63:0]       names_seen;
  logic [7:0]        prev_table_byte;
  logic              table_started;
  asmp_pkg::status_t table_err;

  asmp_pkg::result_t expected_results [$];
  logic [7:0]  map_bytes [$];
  int          mismatch_count = 0;
  int          cycle_count = 0;
  int          burst_left = 0;
  int          sent_count = 0;
  logic [1:0]  stall_mode = 2'd0;
  int          mode_left = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  task automatic clear_parse_state();
    parse_pos = '0;
    hdr_count = '0;
    offset_acc = '0;
    offsets_emitted = '0;
    names_seen = '0;
    prev_table_byte = '0;
    table_started = 1'b0;
    table_err = asmp_pkg::ST_OK;
  endtask

  task automatic predict_parse(input logic [7:0] b, input logic last,
                               output logic produced, output asmp_pkg::result_t res);
    logic got_offset;
    res = '0;
    got_offset = 1'b0;
    if (parse_pos < 64'(asmp_pkg::HDR_BYTES)) begin
      hdr_count = {hdr_count[55:0], b};
    end else if (offsets_emitted < hdr_count) begin
      offset_acc = {offset_acc[55:0], b};
      if (parse_pos[2:0] == 3'd7) begin
        got_offset = 1'b1;
        res.offset_index = offsets_emitted;
        res.member_offset = offset_acc;
        offsets_emitted = offsets_emitted + 64'd1;
        offset_acc = '0;
      end
    end else begin
      if (!table_started) begin
        if (hdr_count != 0 && b == 8'd0 && table_err == asmp_pkg::ST_OK) begin
          table_err = asmp_pkg::ST_BAD_TABLE;
        end
      end else if (b == 8'd0) begin
        if (prev_table_byte == 8'd0) begin
          if (names_seen < hdr_count && table_err == asmp_pkg::ST_OK) begin
            table_err = asmp_pkg::ST_BAD_TABLE;
          end
        end else if (names_seen != '1) begin
          names_seen = names_seen + 64'd1;
        end
      end
      prev_table_byte = b;
      table_started = 1'b1;
    end
    if (parse_pos != '1) parse_pos = parse_pos + 64'd1;

    produced = got_offset || last;
    res.offset_valid = got_offset;
    res.done_res = last;
    res.symbol_count = (parse_pos < 64'(asmp_pkg::HDR_BYTES)) ? 64'd0 : hdr_count;
    if (last) begin
      if (parse_pos < 64'(asmp_pkg::HDR_BYTES) || offsets_emitted < hdr_count) begin
        res.status = asmp_pkg::ST_BAD_COUNT;
      end else if (table_err != asmp_pkg::ST_OK) begin
        res.status = table_err;
      end else if (hdr_count != 0 && !table_started) begin
        res.status = asmp_pkg::ST_BAD_TABLE;
      end else if (names_seen != hdr_count) begin
        res.status = asmp_pkg::ST_BAD_TABLE;
      end else if (b != 8'd0) begin
        res.status = asmp_pkg::ST_BAD_TABLE;
      end
      clear_parse_state();
    end
  endtask

  task automatic report_mismatch(input string field, input logic [63:0] got,
                                 input logic [63:0] want);
    mismatch_count++;
    $display("%0t: %s mismatch, got %h, expected %h", $time, field, got, want);
  endtask

  task automatic check_result();
    asmp_pkg::result_t want;
    if (expected_results.size() == 0) begin
      report_mismatch("unexpected word, member_offset", result_chan.member_offset, 64'd0);
      return;
    end
    want = expected_results.pop_front();
    if (result_chan.offset_valid !== want.offset_valid) begin
      report_mismatch("offset_valid", 64'(result_chan.offset_valid), 64'(want.offset_valid));
    end
    if (result_chan.offset_index !== want.offset_index) begin
      report_mismatch("offset_index", result_chan.offset_index, want.offset_index);
    end
    if (result_chan.member_offset !== want.member_offset) begin
      report_mismatch("member_offset", result_chan.member_offset, want.member_offset);
    end
    if (result_chan.done_res !== want.done_res) begin
      report_mismatch("done_res", 64'(result_chan.done_res), 64'(want.done_res));
    end
    if (result_chan.status !== want.status) begin
      report_mismatch("status", 64'(result_chan.status), 64'(want.status));
    end
    if (result_chan.symbol_count !== want.symbol_count) begin
      report_mismatch("symbol_count", result_chan.symbol_count, want.symbol_count);
    end
  endtask

  // The sender holds valid across words of a burst and drops it only for gaps.
  task automatic send_byte(input logic [7:0] b, input logic last, input logic typed,
                           input logic typed_has, input asmp_pkg::result_t typed_want);
    logic produced;
    asmp_pkg::result_t res;
    if (burst_left == 0) begin
      byte_chan.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 150) :
                                                 $urandom_range(1, 12);
    end
    burst_left--;
    byte_chan.valid <= 1'b1;
    byte_chan.data_byte <= b;
    byte_chan.final_byte <= last;
    do @(posedge clk); while (!byte_chan.ready);
    sent_count++;
    predict_parse(b, last, produced, res);
    if (typed) begin
      if (typed_has) expected_results.push_back(typed_want);
    end else if (produced) begin
      expected_results.push_back(res);
    end
  endtask

  task automatic drain_results();
    byte_chan.valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic build_map();
    int n_sym;
    int len;
    int tbl;
    int r;
    logic [63:0] cnt;
    map_kind_t kind;
    map_bytes.delete();
    r = $urandom_range(0, 17);
    kind = (r < 9) ? MAP_GOOD : map_kind_t'(r - 8);
    n_sym = $urandom_range(0, 4);
    if (n_sym == 0 && (kind == MAP_CUT_OFFSETS || kind == MAP_NO_TABLE ||
                       kind == MAP_LEAD_NUL)) begin
      n_sym = $urandom_range(1, 4);
    end
    cnt = (kind == MAP_NOISE) ? {$urandom, $urandom} : 64'(n_sym);
    for (int i = 0; i < 8; i++) map_bytes.push_back(cnt[63 - 8 * i -: 8]);
    if (kind == MAP_NOISE) begin
      repeat ($urandom_range(0, 16)) map_bytes.push_back(8'($urandom_range(0, 255)));
      return;
    end
    repeat (8 * n_sym) map_bytes.push_back(8'($urandom_range(0, 255)));
    tbl = 8 + 8 * n_sym;
    repeat (n_sym) begin
      repeat ($urandom_range(1, 5)) map_bytes.push_back(8'($urandom_range(1, 255)));
      map_bytes.push_back(8'd0);
    end
    case (kind)
      MAP_CUT_HEADER: begin
        len = $urandom_range(1, 7);
        while (map_bytes.size() > len) void'(map_bytes.pop_back());
      end
      MAP_CUT_OFFSETS: begin
        len = 8 + $urandom_range(0, 8 * n_sym - 1);
        while (map_bytes.size() > len) void'(map_bytes.pop_back());
      end
      MAP_NO_TABLE: begin
        while (map_bytes.size() > tbl) void'(map_bytes.pop_back());
      end
      MAP_LEAD_NUL: begin
        map_bytes.insert(tbl, 8'd0);
      end
      MAP_EXTRA_NUL: begin
        map_bytes.insert($urandom_range(tbl, map_bytes.size()), 8'd0);
      end
      MAP_EXTRA_NAME: begin
        map_bytes.push_back(8'($urandom_range(1, 255)));
        map_bytes.push_back(8'd0);
      end
      MAP_UNTERMINATED: begin
        map_bytes.push_back(8'($urandom_range(1, 255)));
      end
      MAP_PADDED: begin
        repeat ($urandom_range(1, 3)) map_bytes.push_back(8'd0);
      end
      default: begin
      end
    endcase
  endtask

  always @(posedge clk) begin
    if (mode_left == 0) begin
      stall_mode <= 2'($urandom_range(0, 3));
      mode_left <= $urandom_range(20, 200);
    end else begin
      mode_left <= mode_left - 1;
    end
    case (stall_mode)
      2'd0: result_chan.ready <= 1'b1;
      2'd1: result_chan.ready <= 1'($urandom_range(0, 1));
      2'd2: result_chan.ready <= (cycle_count[1:0] == 2'd0);
      default: begin
        if ($urandom_range(0, 9) == 0) result_chan.ready <= ~result_chan.ready;
      end
    endcase
  end

  always @(posedge clk) begin
    if (!rst && result_chan.valid && result_chan.ready) check_result();
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[archive_symbol_map_parser_unit] ERROR");
      $finish;
    end
  end

  initial begin
    byte_chan.valid <= 1'b0;
    byte_chan.data_byte <= 8'd0;
    byte_chan.final_byte <= 1'b0;
    clear_parse_state();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < $size(DIRECTED); i++) begin
      send_byte(DIRECTED[i].data, DIRECTED[i].last, 1'b1, DIRECTED[i].has_exp,
                DIRECTED[i].want);
    end
    drain_results();

    sent_count = 0;
    while (sent_count < RANDOM_BYTES) begin
      build_map();
      if ($urandom_range(0, 9) == 0) drain_results();
      for (int j = 0; j < map_bytes.size(); j++) begin
        send_byte(map_bytes[j], j == map_bytes.size() - 1, 1'b0, 1'b0, NONE_RES);
      end
    end

    byte_chan.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("[archive_symbol_map_parser_unit] OK");
    end else begin
      $display("[archive_symbol_map_parser_unit] ERROR");
    end
    $finish;
  end

endmodule

[archive_symbol_map_parser_unit.f]
src/asmp_pkg.sv
src/asmp_ifs.sv
src/asmp_step.sv
src/archive_symbol_map_parser_unit.sv
src/asmp_check.sv
bench/tb_archive_symbol_map_parser_unit.sv
